[design/aesc_pkg.sv]
// aesc_pkg: shared types, constants and AES byte functions
// used by the round cell, the key schedule and the top level
`default_nettype none
package aesc_pkg;
	localparam int unsigned MaxRounds = 14;
	localparam logic [4:0] BlockBytes = 5'd16;

	typedef logic [127:0] block_t;

	typedef struct packed {
		logic         vld;
		logic [127:0] data;
		logic [4:0]   nbytes;
	} cell_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction
endpackage
`default_nettype wire

[design/aesc_key_sched.sv]
// aesc_key_sched: iterative AES key expansion, one 32-bit word per cycle
// depends on aesc_pkg; produces the 4*(NK+7)-word schedule as round keys
`default_nettype none
module aesc_key_sched #(
	parameter int unsigned NK = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [255:0]       key,
	output logic [59:0][31:0]       words,
	output logic                    busy
);
	import aesc_pkg::*;
	localparam int unsigned Total = 4 * (NK + 7);

	logic [5:0] idx_q;
	logic [5:0] kcnt_q;
	logic [7:0] rcon_q;
	logic [59:0][31:0] w_q;
	logic [31:0] t;
	logic [31:0] prev;
	logic [5:0] back_idx;

	assign prev = w_q[idx_q - 6'd1];
	assign back_idx = idx_q - 6'(NK);

	always_comb begin
		t = prev;
		if (kcnt_q == 6'd0) begin
			t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'd0};
		end else if (NK > 6 && kcnt_q == 6'd4) begin
			t = sub_word(prev);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 6'(NK);
			kcnt_q <= 6'd0;
			rcon_q <= 8'h01;
			busy <= 1'b1;
			w_q <= '0;
		end else if (start) begin
			for (int i = 0; i < 60; i++) begin
				w_q[i] <= (i < 4 * NK / 4 && i < NK) ? key[255 - 32 * i -: 32] : 32'd0;
			end
			idx_q <= 6'(NK);
			kcnt_q <= 6'd0;
			rcon_q <= 8'h01;
			busy <= 1'b1;
		end else if (busy) begin
			w_q[idx_q] <= w_q[back_idx] ^ t;
			if (kcnt_q == 6'd0) rcon_q <= xtime(rcon_q);
			kcnt_q <= (kcnt_q == 6'(NK - 1)) ? 6'd0 : kcnt_q + 6'd1;
			idx_q <= idx_q + 6'd1;
			if (idx_q == 6'(Total - 1)) busy <= 1'b0;
		end
	end

	assign words = w_q;
endmodule
`default_nettype wire

[design/aesc_round_cell.sv]
// aesc_round_cell: one AES round as a cell of the pipeline chain
// depends on aesc_pkg; passes block, keystream state and tags to the next cell
`default_nettype none
module aesc_round_cell (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      bypass,
	input  wire logic      final_rnd,
	input  wire logic [127:0] rk,
	input  aesc_pkg::block_t  st_in,
	input  aesc_pkg::cell_ctl_t ctl_in,
	output aesc_pkg::block_t  st_out,
	output aesc_pkg::cell_ctl_t ctl_out
);
	import aesc_pkg::*;
	logic [7:0] sb [16];
	logic [7:0] sr [16];
	logic [7:0] mc [16];
	block_t nxt;

	always_comb begin
		for (int i = 0; i < 16; i++) sb[i] = SBOX[st_in[127 - 8 * i -: 8]];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) sr[i + 4 * c] = sb[i + 4 * ((c + i) % 4)];
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sr[4 * c]; a1 = sr[4 * c + 1]; a2 = sr[4 * c + 2]; a3 = sr[4 * c + 3];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[4 * c]     = final_rnd ? a0 : a0 ^ al ^ xtime(a0 ^ a1);
			mc[4 * c + 1] = final_rnd ? a1 : a1 ^ al ^ xtime(a1 ^ a2);
			mc[4 * c + 2] = final_rnd ? a2 : a2 ^ al ^ xtime(a2 ^ a3);
			mc[4 * c + 3] = final_rnd ? a3 : a3 ^ al ^ xtime(a3 ^ a0);
		end
		for (int i = 0; i < 16; i++) nxt[127 - 8 * i -: 8] = mc[i] ^ rk[127 - 8 * i -: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_out <= '0;
			ctl_out <= '0;
		end else if (en) begin
			st_out <= bypass ? st_in : nxt;
			ctl_out <= ctl_in;
		end
	end
endmodule
`default_nettype wire

[design/aes_ctr_block_cipher.sv]
// aes_ctr_block_cipher: top level, APB registers, counter, round-cell chain
// depends on aesc_pkg, aesc_key_sched and aesc_round_cell
`default_nettype none
// AES counter-mode encryptor. One item (16 data bytes) is accepted per cycle
// when the output side keeps up; each item passes a chain of fourteen round
// cells and then an output register (rounds beyond the key length pass
// through unchanged). The whole chain advances together and stalls when the
// output is not taken. After reset or a key write the key schedule runs,
// and while it runs no item is accepted.
module aes_ctr_block_cipher #(
	parameter int unsigned KEY_BITS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] in_high,
	input  wire logic [63:0] in_low,
	input  wire logic [4:0]  valid_bytes,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_high,
	output logic [63:0]      out_low,
	output logic [4:0]       valid_bytes_out
);
	import aesc_pkg::*;
	localparam int unsigned NK = (KEY_BITS >= 256) ? 8 : (KEY_BITS >= 192) ? 6 : 4;
	localparam int unsigned NR = NK + 6;
	localparam logic [2:0] RegKey0 = 3'd0, RegKey1 = 3'd1, RegKey2 = 3'd2;
	localparam logic [2:0] RegKey3 = 3'd3, RegCtrHi = 3'd4, RegCtrLo = 3'd5;

	logic [3:0][63:0] key_q;
	logic [63:0] ictr_hi_q, ictr_lo_q;
	logic [127:0] ctr_q;
	logic wr;
	logic [2:0] ridx;
	logic ks_busy;
	logic [59:0][31:0] kw;
	logic adv;
	logic out_vld_q;
	logic [127:0] cur_ctr;
	logic [255:0] key_next;
	block_t st [MaxRounds + 1];
	cell_ctl_t ctl [MaxRounds + 1];
	logic [127:0] rk0;
	logic [127:0] mask;
	logic [4:0] lim;

	assign pready = 1'b1;
	assign ridx = paddr[5:3];
	assign wr = psel && penable && pwrite;

	always_comb begin
		case (ridx)
			RegKey0, RegKey1, RegKey2, RegKey3: prdata = key_q[ridx[1:0]];
			RegCtrHi: prdata = ictr_hi_q;
			RegCtrLo: prdata = ictr_lo_q;
			default: prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			ictr_hi_q <= '0;
			ictr_lo_q <= '0;
		end else if (wr) begin
			if (ridx <= RegKey3) key_q[ridx[1:0]] <= pwdata;
			else if (ridx == RegCtrHi) ictr_hi_q <= pwdata;
			else if (ridx == RegCtrLo) ictr_lo_q <= pwdata;
		end
	end

	// key as it stands after the write in progress
	always_comb begin
		for (int k = 0; k < 4; k++)
			key_next[255 - 64 * k -: 64] = (wr && ridx == 3'(k)) ? pwdata : key_q[k];
	end

	aesc_key_sched #(.NK(NK)) u_ks (
		.clk(clk), .arst_n(arst_n),
		.start(wr && ridx <= RegKey3),
		.key(key_next),
		.words(kw), .busy(ks_busy)
	);

	// chain advances whenever the output register is free or being drained
	assign adv = !out_vld_q || out_ready;
	assign in_ready = adv && !ks_busy;

	assign cur_ctr = restart ? {ictr_hi_q, ictr_lo_q} : ctr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (in_valid && in_ready) begin
			ctr_q <= cur_ctr + 128'd1;
		end
	end

	assign rk0 = {kw[0], kw[1], kw[2], kw[3]};
	assign st[0] = cur_ctr ^ rk0;
	assign ctl[0].vld = in_valid && in_ready;
	assign ctl[0].data = {in_high, in_low};
	assign ctl[0].nbytes = valid_bytes;

	for (genvar r = 1; r <= MaxRounds; r++) begin : g_cell
		aesc_round_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.bypass(r > NR), .final_rnd(r == NR),
			.rk({kw[4 * r], kw[4 * r + 1], kw[4 * r + 2], kw[4 * r + 3]}),
			.st_in(st[r - 1]), .ctl_in(ctl[r - 1]),
			.st_out(st[r]), .ctl_out(ctl[r])
		);
	end

	assign lim = (ctl[MaxRounds].nbytes > BlockBytes) ? BlockBytes : ctl[MaxRounds].nbytes;
	always_comb begin
		for (int i = 0; i < 16; i++) mask[127 - 8 * i -: 8] = (5'(i) < lim) ? 8'hff : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= ctl[MaxRounds].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{out_high, out_low} <= (ctl[MaxRounds].data ^ st[MaxRounds]) & mask;
			valid_bytes_out <= ctl[MaxRounds].nbytes;
		end
	end

	assign out_valid = out_vld_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ks_busy |-> !in_ready) else $error("item taken during key expansion");
	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !restart) |=> ctr_q == $past(ctr_q) + 128'd1)
		else $error("counter did not step");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> $stable(out_high) && $stable(out_low))
		else $error("stalled result changed");
endmodule
`default_nettype wire
